@@ hdl/pjq_pkg.sv @@
// Shared types and constants for the print job queue page sequencer.
`default_nettype none
package pjq_pkg;

  // Widths of the job fields and of the result fields.
  localparam int unsigned OpW     = 2;
  localparam int unsigned PageW   = 7;
  localparam int unsigned StatusW = 3;

  // Request codes.
  typedef enum logic [OpW-1:0] {
    OP_ADD   = 2'd0,
    OP_RANGE = 2'd1,
    OP_FULL  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_PAGE     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  // One stored job.
  typedef struct packed {
    logic [PageW-1:0] doc_pages;
    logic [PageW-1:0] range_first;
    logic [PageW-1:0] range_last;
  } job_t;

  // Commands to the job store.
  typedef struct packed {
    logic push;
    logic pop;
  } store_ctrl_t;

  // Fill state of the job store.
  typedef struct packed {
    logic full;
    logic empty;
  } store_stat_t;

  // Commands to the page counter.
  typedef struct packed {
    logic load;
    logic step;
  } page_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/pjq_in_if.sv @@
// Request channel: valid/ready handshake with one job request as payload.
`default_nettype none
interface pjq_in_if;
  logic                      valid;
  logic                      ready;
  logic [pjq_pkg::OpW-1:0]   opcode;
  logic [pjq_pkg::PageW-1:0] doc_pages;
  logic [pjq_pkg::PageW-1:0] range_first;
  logic [pjq_pkg::PageW-1:0] range_last;

  modport source (output valid, opcode, doc_pages, range_first, range_last, input ready);
  modport sink   (input valid, opcode, doc_pages, range_first, range_last, output ready);
endinterface
`default_nettype wire

@@ hdl/pjq_out_if.sv @@
// Result channel: valid/ready handshake with one result as payload.
`default_nettype none
interface pjq_out_if;
  logic                        valid;
  logic                        ready;
  logic [pjq_pkg::StatusW-1:0] status;
  logic [pjq_pkg::PageW-1:0]   page_number;
  logic                        last;

  modport source (output valid, status, page_number, last, input ready);
  modport sink   (input valid, status, page_number, last, output ready);
endinterface
`default_nettype wire

@@ hdl/print_job_queue_page_sequencer_top.sv @@
// Top level of the print job queue page sequencer.
//
// Requests arrive on in_i: add a job {total, start, end}, print the head job's
// range, or print the head job in full. Results leave on out_o, one transfer
// per result, with last set on the final result of each request.
// An add, a rejected request or a print on an empty queue gives one result,
// registered in the cycle after the request transfer. A print registers the
// head job from the store memory, then in S_READ loads the page counter and
// the output register with its first page, and gives one page per cycle while
// out_o is ready; the page counter steps one page per result transfer. After
// a single-result request the next request is taken in the cycle its result
// is transferred; after a print it is taken the cycle after the last page
// transfer. When out_o stalls, the pending result holds and in_i.ready stays
// low. Reset empties the queue and drops any pending result; stored job
// contents are not cleared.
`default_nettype none
module print_job_queue_page_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_PAGES   = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  pjq_in_if.sink           in_i,
  pjq_out_if.source        out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   full_mode_q;

  logic                        out_valid_q;
  logic [pjq_pkg::StatusW-1:0] out_status_q;
  logic [pjq_pkg::PageW-1:0]   out_page_q;
  logic                        out_last_q;

  pjq_pkg::store_ctrl_t store_ctrl;
  pjq_pkg::store_stat_t store_stat;
  pjq_pkg::job_t        wr_job;
  pjq_pkg::job_t        rd_job;
  pjq_pkg::page_ctrl_t  page_ctrl;

  logic [pjq_pkg::PageW-1:0] first_page;
  logic [pjq_pkg::PageW-1:0] final_page;
  logic                      load_last;
  logic [pjq_pkg::PageW-1:0] next_page;
  logic                      next_last;

  logic in_xfer;
  logic out_xfer;
  logic job_ok;
  pjq_pkg::opcode_e op;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  assign op         = pjq_pkg::opcode_e'(in_i.opcode);

  // Job check on an add request.
  assign job_ok = (in_i.doc_pages != '0) && (in_i.range_first != '0) &&
                  (in_i.range_last >= in_i.range_first) &&
                  (in_i.range_last <= in_i.doc_pages) &&
                  (in_i.doc_pages <= pjq_pkg::PageW'(MAX_PAGES));

  assign wr_job.doc_pages   = in_i.doc_pages;
  assign wr_job.range_first = in_i.range_first;
  assign wr_job.range_last  = in_i.range_last;

  // Store commands from the request decode.
  assign store_ctrl.push = in_xfer && (op == pjq_pkg::OP_ADD) && job_ok && !store_stat.full;
  assign store_ctrl.pop  = in_xfer && ((op == pjq_pkg::OP_RANGE) || (op == pjq_pkg::OP_FULL)) &&
                           !store_stat.empty;

  // Page range of the job just read.
  assign first_page = full_mode_q ? pjq_pkg::PageW'(1) : rd_job.range_first;
  assign final_page = full_mode_q ? rd_job.doc_pages : rd_job.range_last;

  assign page_ctrl.load = (state_q == S_READ);
  assign page_ctrl.step = (state_q == S_EMIT) && out_xfer && !out_last_q;

  pjq_job_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (store_ctrl),
    .wr_job_i (wr_job),
    .rd_job_o (rd_job),
    .stat_o   (store_stat)
  );

  pjq_page_unit u_page (
    .clk_i       (clk_i),
    .ctrl_i      (page_ctrl),
    .first_i     (first_page),
    .final_i     (final_page),
    .load_last_o (load_last),
    .next_page_o (next_page),
    .next_last_o (next_last)
  );

  // Control state and the valid flag of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (store_ctrl.pop) begin
              state_q     <= S_READ;
              out_valid_q <= 1'b0;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_xfer) begin
            out_valid_q <= 1'b0;
          end
        end
        S_READ: begin
          state_q     <= S_EMIT;
          out_valid_q <= 1'b1;
        end
        S_EMIT: begin
          if (out_xfer && out_last_q) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  // Result payload and print mode.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      full_mode_q <= (op == pjq_pkg::OP_FULL);
      out_page_q  <= '0;
      out_last_q  <= 1'b1;
      unique case (op)
        pjq_pkg::OP_ADD: begin
          if (!job_ok) begin
            out_status_q <= pjq_pkg::STAT_INVALID;
          end else if (store_stat.full) begin
            out_status_q <= pjq_pkg::STAT_FULL;
          end else begin
            out_status_q <= pjq_pkg::STAT_ACCEPTED;
          end
        end
        pjq_pkg::OP_RANGE, pjq_pkg::OP_FULL: begin
          out_status_q <= pjq_pkg::STAT_EMPTY;
        end
        default: begin
          out_status_q <= pjq_pkg::STAT_INVALID;
        end
      endcase
    end else if (state_q == S_READ) begin
      out_status_q <= pjq_pkg::STAT_PAGE;
      out_page_q   <= first_page;
      out_last_q   <= load_last;
    end else if (page_ctrl.step) begin
      out_page_q <= next_page;
      out_last_q <= next_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.page_number = out_page_q;
  assign out_o.last        = out_last_q;

endmodule
`default_nettype wire

@@ hdl/pjq_job_store.sv @@
// Circular job store: memory with head and tail pointers and a fill count.
`default_nettype none
module pjq_job_store #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pjq_pkg::store_ctrl_t ctrl_i,
  input  pjq_pkg::job_t        wr_job_i,
  output pjq_pkg::job_t        rd_job_o,
  output pjq_pkg::store_stat_t stat_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(QUEUE_DEPTH - 1);

  pjq_pkg::job_t mem_q [QUEUE_DEPTH];
  pjq_pkg::job_t rd_job_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // Write at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= wr_job_i;
    end
    if (ctrl_i.pop) begin
      rd_job_q <= mem_q[head_q];
    end
  end

  // Pointer and count update; push and pop never come in the same cycle.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d  = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d  = (head_q == LastSlot) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rd_job_o     = rd_job_q;
  assign stat_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule
`default_nettype wire

@@ hdl/pjq_page_unit.sv @@
// Page counter: one shared incrementer and two end-of-range compares.
`default_nettype none
module pjq_page_unit (
  input  wire                        clk_i,
  input  pjq_pkg::page_ctrl_t        ctrl_i,
  input  wire [pjq_pkg::PageW-1:0]   first_i,
  input  wire [pjq_pkg::PageW-1:0]   final_i,
  output logic                       load_last_o,
  output logic [pjq_pkg::PageW-1:0]  next_page_o,
  output logic                       next_last_o
);

  logic [pjq_pkg::PageW-1:0] page_q;
  logic [pjq_pkg::PageW-1:0] final_q;

  // The current page and the final page of the job being printed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      page_q  <= first_i;
      final_q <= final_i;
    end else if (ctrl_i.step) begin
      page_q  <= next_page_o;
    end
  end

  // A one-page range is last from the start.
  assign load_last_o = (first_i == final_i);

  // Next page and whether it ends the range.
  assign next_page_o = page_q + 1'b1;
  assign next_last_o = (next_page_o == final_q);

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the print job queue page sequencer.
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned MaxPages     = 64;
  localparam int unsigned RandomItems  = 302;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned CycleLimit   = 400000;

  // One expected result transfer.
  typedef struct packed {
    pjq_pkg::status_e          status;
    logic [pjq_pkg::PageW-1:0] page_number;
    logic                      last;
  } page_result_t;

  // Tracks the job queue and checks every result transfer against it.
  class print_job_scoreboard;
    pjq_pkg::job_t job_slots[QueueDepth];
    int unsigned   head_slot;
    int unsigned   tail_slot;
    int unsigned   stored_jobs;
    page_result_t  expected_pages[$];
    int unsigned   error_count;

    function int unsigned pending();
      return expected_pages.size();
    endfunction

    function void push_expected(pjq_pkg::status_e st, logic [pjq_pkg::PageW-1:0] pg,
                                logic lst);
      page_result_t res;
      res.status      = st;
      res.page_number = pg;
      res.last        = lst;
      expected_pages.push_back(res);
    endfunction

    // Updates the queue for one accepted request and queues its results.
    function void note_request(pjq_pkg::opcode_e op, logic [pjq_pkg::PageW-1:0] tp,
                               logic [pjq_pkg::PageW-1:0] sp,
                               logic [pjq_pkg::PageW-1:0] ep);
      pjq_pkg::job_t job;
      int            first_pg;
      int            last_pg;
      int            pg;
      case (op)
        pjq_pkg::OP_ADD: begin
          if (tp < 1 || sp < 1 || ep < sp || ep > tp || tp > MaxPages) begin
            push_expected(pjq_pkg::STAT_INVALID, '0, 1'b1);
          end else if (stored_jobs == QueueDepth) begin
            push_expected(pjq_pkg::STAT_FULL, '0, 1'b1);
          end else begin
            job.doc_pages   = tp;
            job.range_first = sp;
            job.range_last  = ep;
            job_slots[tail_slot] = job;
            tail_slot   = (tail_slot + 1) % QueueDepth;
            stored_jobs = stored_jobs + 1;
            push_expected(pjq_pkg::STAT_ACCEPTED, '0, 1'b1);
          end
        end
        pjq_pkg::OP_RANGE, pjq_pkg::OP_FULL: begin
          if (stored_jobs == 0) begin
            push_expected(pjq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            job         = job_slots[head_slot];
            head_slot   = (head_slot + 1) % QueueDepth;
            stored_jobs = stored_jobs - 1;
            first_pg = (op == pjq_pkg::OP_FULL) ? 1 : int'(job.range_first);
            last_pg  = (op == pjq_pkg::OP_FULL) ? int'(job.doc_pages) : int'(job.range_last);
            for (pg = first_pg; pg <= last_pg; pg++) begin
              push_expected(pjq_pkg::STAT_PAGE, pjq_pkg::PageW'(pg), pg == last_pg);
            end
          end
        end
        default: begin
          push_expected(pjq_pkg::STAT_INVALID, '0, 1'b1);
        end
      endcase
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(logic [pjq_pkg::StatusW-1:0] st,
                               logic [pjq_pkg::PageW-1:0] pg, logic lst);
      page_result_t want;
      if (expected_pages.size() == 0) begin
        $display("%0t: unexpected result status=%0d page=%0d last=%0b",
                 $time, st, pg, lst);
        error_count++;
        return;
      end
      want = expected_pages.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        error_count++;
      end
      if (pg !== want.page_number) begin
        $display("%0t: page_number expected %0d actual %0d", $time, want.page_number, pg);
        error_count++;
      end
      if (lst !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, lst);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 66;
  int unsigned cycle_count   = 0;
  print_job_scoreboard page_book;

  pjq_in_if  req_if ();
  pjq_out_if res_if ();

  print_job_queue_page_sequencer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Result side: check each transfer and stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        page_book.check_result(res_if.status, res_if.page_number, res_if.last);
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request after a random gap and waits for its transfer.
  task automatic send_request(pjq_pkg::opcode_e op, logic [pjq_pkg::PageW-1:0] tp,
                              logic [pjq_pkg::PageW-1:0] sp,
                              logic [pjq_pkg::PageW-1:0] ep);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.doc_pages   <= tp;
    req_if.range_first <= sp;
    req_if.range_last  <= ep;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    page_book.note_request(op, tp, sp, ep);
  endtask

  // Mostly well-formed adds and prints; add_share sets the fill or drain bias.
  task automatic send_random_request(int unsigned add_share);
    int unsigned               roll;
    logic [pjq_pkg::PageW-1:0] tp;
    logic [pjq_pkg::PageW-1:0] sp;
    logic [pjq_pkg::PageW-1:0] ep;
    roll = $urandom_range(99);
    if (roll < 6) begin
      send_request(pjq_pkg::OP_ADD, pjq_pkg::PageW'($urandom),
                   pjq_pkg::PageW'($urandom), pjq_pkg::PageW'($urandom));
    end else if (roll < 9) begin
      send_request(pjq_pkg::OP_RSVD, pjq_pkg::PageW'($urandom),
                   pjq_pkg::PageW'($urandom), pjq_pkg::PageW'($urandom));
    end else if (roll < 9 + (add_share * 91) / 100) begin
      tp = ($urandom_range(15) == 0) ? pjq_pkg::PageW'($urandom_range(MaxPages, 1))
                                     : pjq_pkg::PageW'($urandom_range(8, 1));
      sp = pjq_pkg::PageW'($urandom_range(tp, 1));
      ep = pjq_pkg::PageW'($urandom_range(tp, sp));
      send_request(pjq_pkg::OP_ADD, tp, sp, ep);
    end else begin
      send_request($urandom_range(1) ? pjq_pkg::OP_FULL : pjq_pkg::OP_RANGE,
                   pjq_pkg::PageW'($urandom), pjq_pkg::PageW'($urandom),
                   pjq_pkg::PageW'($urandom));
    end
  endtask

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned k;
    page_book = new();
    req_if.valid       <= 1'b0;
    req_if.opcode      <= pjq_pkg::OP_ADD;
    req_if.doc_pages   <= '0;
    req_if.range_first <= '0;
    req_if.range_last  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Prints on an empty queue and the unused opcode.
    send_request(pjq_pkg::OP_RANGE, 7'd0, 7'd0, 7'd0);
    send_request(pjq_pkg::OP_FULL, 7'd127, 7'd127, 7'd127);
    send_request(pjq_pkg::OP_RSVD, 7'd127, 7'd127, 7'd127);

    // Each way a job can be rejected.
    send_request(pjq_pkg::OP_ADD, 7'd0, 7'd0, 7'd0);
    send_request(pjq_pkg::OP_ADD, 7'd10, 7'd0, 7'd5);
    send_request(pjq_pkg::OP_ADD, 7'd10, 7'd6, 7'd5);
    send_request(pjq_pkg::OP_ADD, 7'd10, 7'd3, 7'd11);
    send_request(pjq_pkg::OP_ADD, 7'd65, 7'd1, 7'd1);
    send_request(pjq_pkg::OP_ADD, 7'd127, 7'd127, 7'd127);

    // Fill the queue to the brim, with the largest jobs first, then overflow it.
    send_request(pjq_pkg::OP_ADD, 7'd64, 7'd1, 7'd64);
    send_request(pjq_pkg::OP_ADD, 7'd64, 7'd64, 7'd64);
    send_request(pjq_pkg::OP_ADD, 7'd1, 7'd1, 7'd1);
    for (k = 0; k < QueueDepth - 3; k++) begin
      send_request(pjq_pkg::OP_ADD, pjq_pkg::PageW'(k + 2), 7'd2, pjq_pkg::PageW'(k + 2));
    end
    send_request(pjq_pkg::OP_ADD, 7'd5, 7'd2, 7'd3);

    // Longest range print, then a full print of a one-page range job.
    send_request(pjq_pkg::OP_RANGE, 7'd0, 7'd0, 7'd0);
    send_request(pjq_pkg::OP_FULL, 7'd0, 7'd0, 7'd0);

    // Random requests over three idling phases.
    for (k = 0; k < RandomItems; k++) begin
      if (k == RandomItems / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 34;
      end
      if (k == (2 * RandomItems) / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_request(((k / 40) % 2 == 0) ? 70 : 30);
    end
    req_if.valid <= 1'b0;

    // Drain the outstanding results, then allow for any stray transfer.
    while (page_book.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (page_book.error_count == 0 && page_book.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
